@@ src/mpd_pkg.sv @@
package mpd_pkg;

    localparam int DATA_W     = 8;
    localparam int BTN_W      = 3;
    localparam int MOVE_X_W   = 9;
    localparam int MOVE_Y_W   = 10;
    localparam int CURSOR_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 2;

    localparam logic [DATA_W-1:0] SYNC_MASK     = 8'h08;
    localparam logic [DATA_W-1:0] OVERFLOW_MASK = 8'hC0;

    localparam int BTN_LSB  = 0;
    localparam int X_SIGN   = 4;
    localparam int Y_SIGN   = 5;

    localparam logic [CFG_DATA_W-1:0] SCREEN_W_RESET = 16'd1024;
    localparam logic [CFG_DATA_W-1:0] SCREEN_H_RESET = 16'd768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_W = 1'b0,
        CFG_SCREEN_H = 1'b1
    } cfg_reg_t;

    typedef enum logic [COUNT_W-1:0] {
        CNT_FLAG = 2'd0,
        CNT_X    = 2'd1,
        CNT_Y    = 2'd2
    } byte_count_t;

endpackage

@@ src/mpd_byte_if.sv @@
interface mpd_byte_if
    import mpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

@@ src/mpd_report_if.sv @@
interface mpd_report_if
    import mpd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic        [BTN_W-1:0]    buttons;
    logic signed [MOVE_X_W-1:0] move_x;
    logic signed [MOVE_Y_W-1:0] move_y;
    logic        [CURSOR_W-1:0] cursor_x;
    logic        [CURSOR_W-1:0] cursor_y;

    modport source (output valid, output buttons, output move_x, output move_y,
                    output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input buttons, input move_x, input move_y,
                    input cursor_x, input cursor_y, output ready);
endinterface

@@ src/mouse_packet_decoder_cursor.sv @@
// Mouse packet decoder with a clamped cursor. Each beat on bytes carries one
// controller byte and a flag marking it as coming from the mouse port; other
// bytes are dropped without effect. A first byte without the sync bit (bit 3)
// or with an overflow bit set is dropped to regain packet sync. The third byte
// of a packet yields one beat on reports: buttons, sign-extended X move, the
// negated Y move (down positive) and the cursor after it is moved and clamped
// to 0 .. screen size - 1 (0 for a size of zero). The cursor starts at
// (100, 100) and the screen size at 1024 x 768; cfg_index 0 writes the width,
// 1 the height; the user must write these only while no bytes are in flight,
// since the block does not enforce it. A byte is accepted every cycle unless
// a stall holds it: it waits in an input register, is decoded in a single pass
// into the state and the report register, so a report is valid once the beat
// completing its packet has passed both. The report register is the only
// back-pressure point; a full, unread report holds the byte that would complete the next packet.
module mouse_packet_decoder_cursor
    import mpd_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mpd_byte_if.sink              bytes,
    mpd_report_if.source          reports
);

    localparam int CW = ((COORD_BITS > CFG_DATA_W) ? COORD_BITS : CFG_DATA_W) + 2;
    localparam logic [CW-1:0] COORD_MASK = {{(CW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
    localparam logic [COORD_BITS-1:0] POS_RESET = COORD_BITS'(100);

    logic [CFG_DATA_W-1:0] screen_w_reg;
    logic [CFG_DATA_W-1:0] screen_h_reg;

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_aux_reg;

    byte_count_t       count_reg, count_next;
    logic [DATA_W-1:0] flag_reg, flag_next;
    logic [DATA_W-1:0] x_byte_reg, x_byte_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;

    logic                       out_valid_reg;
    logic        [BTN_W-1:0]    buttons_reg;
    logic signed [MOVE_X_W-1:0] move_x_reg;
    logic signed [MOVE_Y_W-1:0] move_y_reg;
    logic        [CURSOR_W-1:0] cursor_x_reg, cursor_x_next;
    logic        [CURSOR_W-1:0] cursor_y_reg, cursor_y_next;

    logic completes;
    logic out_free;
    logic fire;
    logic signed [MOVE_X_W-1:0] dx;
    logic signed [MOVE_Y_W-1:0] neg_dy;
    logic [CW-1:0] cx_wide;
    logic [CW-1:0] cy_wide;

    function automatic logic [CW-1:0] clamp_axis(
        input logic [COORD_BITS-1:0] pos,
        input logic signed [MOVE_Y_W-1:0] delta,
        input logic [CFG_DATA_W-1:0] size
    );
        logic signed [CW-1:0] p;
        logic [CW-1:0] top;
        logic [CW-1:0] res;
        p   = $signed({{(CW-COORD_BITS){1'b0}}, pos}) + CW'(delta);
        top = (size == '0) ? '0 : CW'(size) - CW'(1);
        if (top > COORD_MASK)
        begin
            top = COORD_MASK;
        end
        if (p < 0)
        begin
            res = '0;
        end
        else if ($unsigned(p) > top)
        begin
            res = top;
        end
        else
        begin
            res = $unsigned(p);
        end
        return res;
    endfunction

    assign completes = in_aux_reg && (count_reg != CNT_FLAG) && (count_reg != CNT_X);
    assign out_free  = !out_valid_reg || reports.ready;
    assign fire      = in_valid_reg && (!completes || out_free);
    assign bytes.ready = !in_valid_reg || fire;

    assign dx     = $signed({flag_reg[X_SIGN], x_byte_reg});
    assign neg_dy = -$signed({flag_reg[Y_SIGN], flag_reg[Y_SIGN], in_data_reg});

    assign cx_wide = clamp_axis(pos_x_reg, MOVE_Y_W'(dx), screen_w_reg);
    assign cy_wide = clamp_axis(pos_y_reg, neg_dy, screen_h_reg);

    always_comb
    begin
        count_next    = count_reg;
        flag_next     = flag_reg;
        x_byte_next   = x_byte_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        cursor_x_next = cx_wide[CURSOR_W-1:0];
        cursor_y_next = cy_wide[CURSOR_W-1:0];
        if (fire && in_aux_reg)
        begin
            unique case (count_reg)
                CNT_FLAG:
                begin
                    if (((in_data_reg & SYNC_MASK) != '0) &&
                        ((in_data_reg & OVERFLOW_MASK) == '0))
                    begin
                        flag_next  = in_data_reg;
                        count_next = CNT_X;
                    end
                end
                CNT_X:
                begin
                    x_byte_next = in_data_reg;
                    count_next  = CNT_Y;
                end
                default:
                begin
                    pos_x_next = cx_wide[COORD_BITS-1:0];
                    pos_y_next = cy_wide[COORD_BITS-1:0];
                    count_next = CNT_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= SCREEN_W_RESET;
            screen_h_reg <= SCREEN_H_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCREEN_W: screen_w_reg <= cfg_data;
                CFG_SCREEN_H: screen_h_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= CNT_FLAG;
            flag_reg      <= '0;
            x_byte_reg    <= '0;
            pos_x_reg     <= POS_RESET;
            pos_y_reg     <= POS_RESET;
        end
        else
        begin
            if (bytes.ready)
            begin
                in_valid_reg <= bytes.valid;
            end
            if (fire && completes)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (reports.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg  <= count_next;
            flag_reg   <= flag_next;
            x_byte_reg <= x_byte_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_data_reg <= bytes.data_byte;
            in_aux_reg  <= bytes.from_aux;
        end
        if (fire && completes)
        begin
            buttons_reg  <= flag_reg[BTN_LSB +: BTN_W];
            move_x_reg   <= dx;
            move_y_reg   <= neg_dy;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    assign reports.valid    = out_valid_reg;
    assign reports.buttons  = buttons_reg;
    assign reports.move_x   = move_x_reg;
    assign reports.move_y   = move_y_reg;
    assign reports.cursor_x = cursor_x_reg;
    assign reports.cursor_y = cursor_y_reg;

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_FLAG || count_reg == CNT_X || count_reg == CNT_Y)
        else $error("byte count left the packet range");

    a_report_after_packet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire && completes))
        else $error("report raised without a completed packet");

    a_packet_loads_report: assert property (@(posedge clk) disable iff (!rst_n)
        fire && completes |=> out_valid_reg && count_reg == CNT_FLAG)
        else $error("completed packet did not load the report");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> in_valid_reg && completes && out_valid_reg && !reports.ready)
        else $error("byte stalled without a blocked report");

endmodule

@@ sim/tb_mouse_packet_decoder_cursor.sv @@
`timescale 1ns / 100ps

module tb_mouse_packet_decoder_cursor;
    import mpd_pkg::*;

    localparam int COORD_BITS   = 16;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic        [BTN_W-1:0]    buttons;
        logic signed [MOVE_X_W-1:0] move_x;
        logic signed [MOVE_Y_W-1:0] move_y;
        logic        [CURSOR_W-1:0] cursor_x;
        logic        [CURSOR_W-1:0] cursor_y;
    } report_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mpd_byte_if   byte_ch ();
    mpd_report_if rpt_ch ();

    mouse_packet_decoder_cursor #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (byte_ch),
        .reports   (rpt_ch)
    );

    // decoder state as seen from outside
    byte_count_t       pkt_phase   = CNT_FLAG;
    logic [DATA_W-1:0] hdr_byte    = '0;
    logic [DATA_W-1:0] x_move_byte = '0;
    int                cur_x       = 100;
    int                cur_y       = 100;
    int                width_cfg   = SCREEN_W_RESET;
    int                height_cfg  = SCREEN_H_RESET;

    report_t reports_due[$];
    int      mismatch_count    = 0;
    int      cycle_count       = 0;
    int      sender_idle_pct   = 0;
    int      report_stall_pct  = 0;
    logic    report_hold       = 1'b0;
    event    report_hold_start;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_to_screen(int pos, int delta, int size);
        int p;
        int top;
        p   = pos + delta;
        top = (size == 0) ? 0 : size - 1;
        if (top > COORD_MAX)
            top = COORD_MAX;
        if (p < 0)
            p = 0;
        if (p > top)
            p = top;
        return p;
    endfunction

    task automatic decode_mouse_byte(input logic [DATA_W-1:0] d, input logic aux);
        int      dx;
        int      dy;
        report_t rep;
        if (aux)
        begin
            case (pkt_phase)
                CNT_FLAG:
                begin
                    if ((d & SYNC_MASK) != 0 && (d & OVERFLOW_MASK) == 0)
                    begin
                        hdr_byte  = d;
                        pkt_phase = CNT_X;
                    end
                end
                CNT_X:
                begin
                    x_move_byte = d;
                    pkt_phase   = CNT_Y;
                end
                default:
                begin
                    dx = int'(x_move_byte) - (hdr_byte[X_SIGN] ? 256 : 0);
                    dy = int'(d) - (hdr_byte[Y_SIGN] ? 256 : 0);
                    cur_x = clamp_to_screen(cur_x, dx, width_cfg);
                    cur_y = clamp_to_screen(cur_y, -dy, height_cfg);
                    dy = -dy;
                    rep.buttons  = hdr_byte[BTN_LSB +: BTN_W];
                    rep.move_x   = dx[MOVE_X_W-1:0];
                    rep.move_y   = dy[MOVE_Y_W-1:0];
                    rep.cursor_x = cur_x[CURSOR_W-1:0];
                    rep.cursor_y = cur_y[CURSOR_W-1:0];
                    reports_due.push_back(rep);
                    pkt_phase = CNT_FLAG;
                end
            endcase
        end
    endtask

    task automatic send_byte(input logic [DATA_W-1:0] d, input logic aux);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.from_aux  <= aux;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        decode_mouse_byte(d, aux);
    endtask

    task automatic send_packet(input logic [DATA_W-1:0] hdr, input logic [DATA_W-1:0] xb,
                               input logic [DATA_W-1:0] yb);
        send_byte(hdr, 1'b1);
        send_byte(xb, 1'b1);
        send_byte(yb, 1'b1);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_screen_reg(input cfg_reg_t idx, input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SCREEN_W)
            width_cfg = value & 16'hFFFF;
        else
            height_cfg = value & 16'hFFFF;
    endtask

    task automatic set_screen(input int w, input int h);
        wait_idle();
        write_screen_reg(CFG_SCREEN_W, w);
        write_screen_reg(CFG_SCREEN_H, h);
    endtask

    task automatic send_random_stream(input int n_aux);
        int                sent;
        int                pick;
        logic [DATA_W-1:0] hdr;
        sent = 0;
        while (sent < n_aux)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_byte(8'($urandom), 1'b0);
            end
            else if (pick < 16)
            begin
                send_byte(8'($urandom), 1'b1);
                sent++;
            end
            else
            begin
                hdr = (8'($urandom) & ~OVERFLOW_MASK) | SYNC_MASK;
                send_packet(hdr, 8'($urandom), 8'($urandom));
                sent += 3;
            end
        end
    endtask

    task automatic test_directed_packets();
        send_byte(8'hFF, 1'b0);
        send_packet(SYNC_MASK, 8'h00, 8'h00);
        send_byte(8'h00, 1'b1);
        send_byte(8'h48, 1'b1);
        send_byte(8'h88, 1'b1);
        send_byte(8'hF7, 1'b1);
        // max positive moves, all buttons, with a foreign byte mid-packet
        send_byte(SYNC_MASK | 8'h07, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(SYNC_MASK, 1'b0);
        send_byte(8'hFF, 1'b1);
        // most negative moves on both axes
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'h3A, 8'h80, 8'h7F);
        send_packet(8'h1D, 8'h55, 8'hAA);
    endtask

    task automatic test_screen_limits();
        set_screen(1, 1);
        send_packet(SYNC_MASK, 8'h10, 8'h10);
        send_packet(8'h38, 8'hF0, 8'h10);
        set_screen(0, 0);
        send_packet(8'h28, 8'h7F, 8'h00);
        set_screen(65535, 65535);
        repeat (4) send_packet(8'h2F, 8'hFF, 8'h00);
        // shrink below the cursor, then let a still packet pull it in
        set_screen(300, 200);
        send_packet(SYNC_MASK, 8'h00, 8'h00);
        send_packet(8'h18, 8'h00, 8'h01);
        set_screen(1024, 768);
        send_packet(SYNC_MASK, 8'hFF, 8'h00);
    endtask

    task automatic test_random_phase(input int w, input int h, input int s_idle,
                                     input int r_stall, input int n_aux);
        set_screen(w, h);
        sender_idle_pct  = s_idle;
        report_stall_pct = r_stall;
        send_random_stream(n_aux);
    endtask

    task automatic test_report_backpressure();
        wait_idle();
        sender_idle_pct  = 0;
        report_stall_pct = 0;
        -> report_hold_start;
        send_random_stream(90);
    endtask

    initial
    begin
        forever
        begin
            @(report_hold_start);
            report_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            report_hold <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        rpt_ch.ready <= !report_hold && ($urandom_range(99) >= report_stall_pct);
    end

    always @(posedge clk)
    begin : report_check
        report_t want;
        if (rst_n && rpt_ch.valid && rpt_ch.ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected report beat: buttons %0d move_x %0d move_y %0d",
                       rpt_ch.buttons, rpt_ch.move_x, rpt_ch.move_y);
                mismatch_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (rpt_ch.buttons !== want.buttons)
                begin
                    $error("buttons expected %0d got %0d", want.buttons, rpt_ch.buttons);
                    mismatch_count++;
                end
                if (rpt_ch.move_x !== want.move_x)
                begin
                    $error("move_x expected %0d got %0d", want.move_x, rpt_ch.move_x);
                    mismatch_count++;
                end
                if (rpt_ch.move_y !== want.move_y)
                begin
                    $error("move_y expected %0d got %0d", want.move_y, rpt_ch.move_y);
                    mismatch_count++;
                end
                if (rpt_ch.cursor_x !== want.cursor_x)
                begin
                    $error("cursor_x expected %0d got %0d", want.cursor_x, rpt_ch.cursor_x);
                    mismatch_count++;
                end
                if (rpt_ch.cursor_y !== want.cursor_y)
                begin
                    $error("cursor_y expected %0d got %0d", want.cursor_y, rpt_ch.cursor_y);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[mouse_packet_decoder_cursor] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= CFG_SCREEN_W;
        cfg_data          <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.from_aux  <= 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_packets();
        test_screen_limits();
        test_random_phase(1024, 768, 0, 0, 350);
        test_random_phase(65535, 1, 75, 0, 340);
        test_random_phase($urandom_range(1, 65535), $urandom_range(1, 65535), 0, 75, 340);
        test_random_phase(200, 150, 22, 22, 340);
        test_report_backpressure();

        wait_idle();
        if (mismatch_count == 0)
            $display("[mouse_packet_decoder_cursor] OK");
        else
            $display("[mouse_packet_decoder_cursor] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/mpd_pkg.sv
src/mpd_byte_if.sv
src/mpd_report_if.sv
src/mouse_packet_decoder_cursor.sv
sim/tb_mouse_packet_decoder_cursor.sv
